FILE: rtl/srs_pkg.sv
`timescale 1ns / 1ps
package srs_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [21:0] COUNT_MAX = 22'h3F_FFFF;

  localparam logic [2:0] REG_OFFSET_X    = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z    = 3'd2;
  localparam logic [2:0] REG_SPACING_X   = 3'd3;
  localparam logic [2:0] REG_SPACING_Y   = 3'd4;
  localparam logic [2:0] REG_SPACING_Z   = 3'd5;
  localparam logic [2:0] REG_RADIUS_SQ   = 3'd6;
  localparam logic [2:0] REG_CELL_VOLUME = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_DENS = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  typedef struct packed {
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic [6:0]         cell_z;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic [30:0]        density;
    logic [30:0]        internal_energy;
    logic signed [31:0] potential;
    logic               last_cell;
  } in_t;

  typedef struct packed {
    logic signed [63:0] mass_sum;
    logic signed [63:0] kinetic_sum;
    logic signed [63:0] thermal_sum;
    logic signed [63:0] potential_sum;
    logic signed [63:0] total_sum;
    logic [21:0]        cells_inside;
    logic [1:0]         status;
  } out_t;

  // one classified cell handed from front to back
  typedef struct packed {
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic [30:0]        density;
    logic [30:0]        internal_energy;
    logic signed [31:0] potential;
    logic               last_cell;
    logic               in_sphere;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic [30:0]        spacing_x;
    logic [30:0]        spacing_y;
    logic [30:0]        spacing_z;
    logic [62:0]        radius_sq_limit;
  } geom_cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_OFFS, F_SQ, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_DIV, B_ACC, B_SCALE_HI, B_SCALE_LO, B_SCALE_FIX,
    B_TOT_A, B_TOT_B, B_OUT
  } back_state_t;

  // saturating signed add; bit 64 flags a clamp
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    logic               ovf;
    s   = a + b;
    ovf = (a[63] == b[63]) && (s[63] != a[63]);
    return {ovf, ovf ? (a[63] ? S64_MIN : S64_MAX) : s};
  endfunction

endpackage

FILE: rtl/srs_fifo.sv
`timescale 1ns / 1ps
module srs_fifo #(
  parameter type ITEM_T = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  ITEM_T wr_item,
  output logic  full,
  input  logic  rd_en,
  output ITEM_T rd_item,
  output logic  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ITEM_T         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: rtl/srs_front.sv
`timescale 1ns / 1ps
module srs_front import srs_pkg::*; #(
  parameter int MESH_SIDE = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_t       in_item,
  input  geom_cfg_t cfg,
  output logic      q_wr,
  output cell_t     q_item,
  input  logic      q_full
);
  localparam logic [10:0] SIDE = 11'(MESH_SIDE);

  front_state_t state, state_next;
  in_t          item;
  logic [1:0]   axis;
  logic [31:0]  e;
  logic         odd;
  logic         over;
  logic         in_range;
  logic [63:0]  sum;

  logic signed [31:0] off;
  logic [6:0]         idx;
  logic [30:0]        sp;
  logic [38:0]        span_prod;
  logic signed [41:0] d;
  logic [41:0]        mag;
  logic [63:0]        sq;
  logic [64:0]        sum65;
  logic               in_sphere;
  logic               keep;

  always_comb begin
    case (axis)
      2'd0:    begin off = cfg.offset_x; idx = item.cell_x; sp = cfg.spacing_x; end
      2'd1:    begin off = cfg.offset_y; idx = item.cell_y; sp = cfg.spacing_y; end
      default: begin off = cfg.offset_z; idx = item.cell_z; sp = cfg.spacing_z; end
    endcase
    span_prod = 39'({idx, 1'b1}) * 39'(sp);
    d   = $signed({{9{off[31]}}, off, 1'b0}) + $signed({3'b000, span_prod});
    mag = d[41] ? 42'(-d) : 42'(d);
    sq  = 64'(e) * 64'(e) + (odd ? 64'(e) : 64'd0);
    sum65 = {1'b0, sum} + {1'b0, sq};
  end

  assign in_sphere = in_range && !over && (sum <= {1'b0, cfg.radius_sq_limit});
  assign keep      = in_sphere || item.last_cell;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) state_next = F_OFFS;
      F_OFFS: state_next = F_SQ;
      F_SQ:   state_next = (axis == 2'd2) ? F_PUSH : F_OFFS;
      F_PUSH: if (!keep || !q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full = (state != F_IDLE);
    q_wr = (state == F_PUSH) && keep && !q_full;
    q_item.momentum_x      = item.momentum_x;
    q_item.momentum_y      = item.momentum_y;
    q_item.momentum_z      = item.momentum_z;
    q_item.density         = item.density;
    q_item.internal_energy = item.internal_energy;
    q_item.potential       = item.potential;
    q_item.last_cell       = item.last_cell;
    q_item.in_sphere       = in_sphere;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (push) begin
          item     <= in_item;
          axis     <= 2'd0;
          over     <= 1'b0;
          sum      <= '0;
          in_range <= ({4'b0, in_item.cell_x} < SIDE) && ({4'b0, in_item.cell_y} < SIDE)
                      && ({4'b0, in_item.cell_z} < SIDE);
        end
      end
      F_OFFS: begin
        e   <= mag[32:1];
        odd <= mag[0];
        if (mag[41:33] != '0) over <= 1'b1;
      end
      F_SQ: begin
        sum  <= sum65[63:0];
        if (sum65[64]) over <= 1'b1;
        axis <= axis + 2'd1;
      end
      default: begin
      end
    endcase
  end
endmodule

FILE: rtl/srs_back.sv
`timescale 1ns / 1ps
module srs_back import srs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] cell_volume,
  output logic        q_rd,
  input  cell_t       q_item,
  input  logic        q_empty,
  output logic        out_wr,
  output out_t        out_item,
  input  logic        out_full
);
  back_state_t state, state_next;
  cell_t       ent;
  logic [5:0]  cnt;
  logic [1:0]  sidx;
  logic [63:0] sq;
  logic [63:0] therm;
  logic [62:0] pmag;
  logic [63:0] quo;
  logic [32:0] rem;
  logic signed [63:0] acc [4];
  logic signed [63:0] scaled [4];
  logic [21:0] count;
  logic [1:0]  flags;
  logic [63:0] phi;
  logic [63:0] plo;
  logic        neg;
  logic signed [63:0] tk;
  logic signed [63:0] tot;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] ax, ay, az, apot;
  logic [63:0] mag_acc;
  logic [32:0] rsh;
  logic [32:0] dvs;
  logic [63:0] pup;
  logic signed [63:0] pterm;
  logic signed [63:0] kterm;
  logic [64:0] r_m, r_k, r_t, r_p, r_tk, r_tot;
  logic [64:0] t65;
  logic [63:0] t;
  logic        sat;
  logic signed [63:0] sres;

  always_comb begin
    ax   = ent.momentum_x[31] ? 32'(-ent.momentum_x) : 32'(ent.momentum_x);
    ay   = ent.momentum_y[31] ? 32'(-ent.momentum_y) : 32'(ent.momentum_y);
    az   = ent.momentum_z[31] ? 32'(-ent.momentum_z) : 32'(ent.momentum_z);
    apot = ent.potential[31] ? 32'(-ent.potential) : 32'(ent.potential);
    mag_acc = acc[sidx][63] ? 64'(-acc[sidx]) : 64'(acc[sidx]);
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_MUL: begin
        case (cnt[2:0])
          3'd0:    begin mul_a = ax; mul_b = ax; end
          3'd1:    begin mul_a = ay; mul_b = ay; end
          3'd2:    begin mul_a = az; mul_b = az; end
          3'd3:    begin mul_a = {1'b0, ent.internal_energy}; mul_b = {1'b0, ent.density}; end
          default: begin mul_a = apot; mul_b = {1'b0, ent.density}; end
        endcase
      end
      B_SCALE_HI: begin mul_a = mag_acc[63:32]; mul_b = cell_volume; end
      B_SCALE_LO: begin mul_a = mag_acc[31:0];  mul_b = cell_volume; end
      default: begin
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);

    // one restoring divide step by twice the density
    dvs = {1'b0, ent.density, 1'b0};
    rsh = {rem[31:0], quo[63]};

    // potential term floors toward minus infinity
    pup   = (64'(pmag) + 64'h1FFFF) >> 17;
    pterm = ent.potential[31] ? $signed(-pup) : $signed(64'(pmag) >> 17);
    kterm = (ent.density == '0) ? 64'sd0 : $signed(quo);
    r_m = sat_add(acc[0], $signed({33'b0, ent.density}));
    r_k = sat_add(acc[1], kterm);
    r_t = sat_add(acc[2], $signed(therm));
    r_p = sat_add(acc[3], pterm);

    t65  = {1'b0, phi[31:0], 32'b0} + {1'b0, plo};
    t    = t65[63:0];
    sat  = (phi[63:32] != '0) || t65[64] || (!neg && t[63]) || (neg && t[63] && (t[62:0] != '0));
    sres = sat ? (neg ? S64_MIN : S64_MAX) : (neg ? $signed(-t) : $signed(t));

    r_tk  = sat_add(scaled[1], scaled[2]);
    r_tot = sat_add(tk, scaled[3]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (!q_empty) state_next = q_item.in_sphere ? B_MUL : B_SCALE_HI;
      B_MUL:       if (cnt == 6'd4) state_next = (ent.density == '0) ? B_ACC : B_DIV;
      B_DIV:       if (cnt == 6'd63) state_next = B_ACC;
      B_ACC:       state_next = ent.last_cell ? B_SCALE_HI : B_IDLE;
      B_SCALE_HI:  state_next = B_SCALE_LO;
      B_SCALE_LO:  state_next = B_SCALE_FIX;
      B_SCALE_FIX: state_next = (sidx == 2'd3) ? B_TOT_A : B_SCALE_HI;
      B_TOT_A:     state_next = B_TOT_B;
      B_TOT_B:     state_next = B_OUT;
      B_OUT:       if (!out_full) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_rd   = (state == B_IDLE) && !q_empty;
    out_wr = (state == B_OUT) && !out_full;
    out_item.mass_sum      = scaled[0];
    out_item.kinetic_sum   = scaled[1];
    out_item.thermal_sum   = scaled[2];
    out_item.potential_sum = scaled[3];
    out_item.total_sum     = tot;
    out_item.cells_inside  = count;
    out_item.status        = flags[1] ? ST_SAT : (flags[0] ? ST_ZERO_DENS : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
      sidx  <= '0;
      count <= '0;
      flags <= '0;
      for (int i = 0; i < 4; i++) acc[i] <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      case (state)
        B_IDLE: begin
          sidx <= '0;
        end
        B_ACC: begin
          acc[0] <= r_m[63:0];
          acc[1] <= r_k[63:0];
          acc[2] <= r_t[63:0];
          acc[3] <= r_p[63:0];
          if (r_m[64] || r_k[64] || r_t[64] || r_p[64]) flags[1] <= 1'b1;
          if (ent.density == '0) flags[0] <= 1'b1;
          if (count < COUNT_MAX) count <= count + 22'd1;
          sidx <= '0;
        end
        B_SCALE_FIX: begin
          if (sat) flags[1] <= 1'b1;
          sidx <= sidx + 2'd1;
        end
        B_TOT_A: if (r_tk[64]) flags[1] <= 1'b1;
        B_TOT_B: if (r_tot[64]) flags[1] <= 1'b1;
        B_OUT: begin
          if (!out_full) begin
            // sweep done: drop the sums
            count <= '0;
            flags <= '0;
            for (int i = 0; i < 4; i++) acc[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (!q_empty) ent <= q_item;
      B_MUL: begin
        case (cnt[2:0])
          3'd0:    sq <= prod;
          3'd1:    sq <= sq + prod;
          3'd2:    sq <= sq + prod;
          3'd3:    therm <= {16'b0, prod[63:16]};
          default: begin
            pmag <= prod[62:0];
            quo  <= sq;
            rem  <= '0;
          end
        endcase
      end
      B_DIV: begin
        if (rsh >= dvs) begin
          rem <= rsh - dvs;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rsh;
          quo <= {quo[62:0], 1'b0};
        end
      end
      B_SCALE_HI: begin
        phi <= prod;
        neg <= acc[sidx][63];
      end
      B_SCALE_LO:  plo <= prod;
      B_SCALE_FIX: scaled[sidx] <= sres;
      B_TOT_A:     tk <= r_tk[63:0];
      B_TOT_B:     tot <= r_tot[63:0];
      default: begin
      end
    endcase
  end
endmodule

FILE: rtl/spherical_region_energy_sums_top.sv
`timescale 1ns / 1ps
// Spherical region energy sums over a stream of mesh cells.
// Input channel: present one cell on in_item, raise push; the cell is taken
// at a rising edge with push high and full low. Result channel: while empty
// is low the oldest result sits on out_item; raise pop to take it.
// Configuration: cfg_we writes cfg_data to register cfg_index at the edge;
// write only while no cell is in flight. Unknown indices are ignored.
// The front classifies a cell against the sphere one axis at a time, through
// the offset multiply and the square, then hands it to a 2-entry queue;
// outside cells that are not last are dropped there.
// The back forms the five products, runs a bit-serial divider for the
// kinetic term (skipped at zero density) and then adds. A last cell also
// scales the four sums by cell_volume and forms the total.
// While the result queue (2 entries) is full the back holds its result and
// the front keeps taking cells until the middle queue fills.
// Reset restores the register defaults, clears sums, count, status, queues.
module spherical_region_energy_sums_top import srs_pkg::*; #(
  parameter int MESH_SIDE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         in_item,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);
  geom_cfg_t   geom;
  logic [31:0] cell_volume;

  logic  mid_wr, mid_full, mid_rd, mid_empty;
  cell_t mid_wr_item, mid_rd_item;
  logic  res_wr, res_full;
  out_t  res_item;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.offset_x        <= '0;
      geom.offset_y        <= '0;
      geom.offset_z        <= '0;
      geom.spacing_x       <= 31'd65536;
      geom.spacing_y       <= 31'd65536;
      geom.spacing_z       <= 31'd65536;
      geom.radius_sq_limit <= 63'h1_0000_0000;
      cell_volume          <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X:    geom.offset_x        <= cfg_data[31:0];
        REG_OFFSET_Y:    geom.offset_y        <= cfg_data[31:0];
        REG_OFFSET_Z:    geom.offset_z        <= cfg_data[31:0];
        REG_SPACING_X:   geom.spacing_x       <= cfg_data[30:0];
        REG_SPACING_Y:   geom.spacing_y       <= cfg_data[30:0];
        REG_SPACING_Z:   geom.spacing_z       <= cfg_data[30:0];
        REG_RADIUS_SQ:   geom.radius_sq_limit <= cfg_data;
        REG_CELL_VOLUME: cell_volume          <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // classify each cell against the sphere
  srs_front #(.MESH_SIDE(MESH_SIDE)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cfg     (geom),
    .q_wr    (mid_wr),
    .q_item  (mid_wr_item),
    .q_full  (mid_full)
  );

  // decouple front from back
  srs_fifo #(.ITEM_T(cell_t), .DEPTH(2)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_item (mid_wr_item),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_item (mid_rd_item),
    .empty   (mid_empty)
  );

  // accumulate and finish the sweep
  srs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cell_volume (cell_volume),
    .q_rd        (mid_rd),
    .q_item      (mid_rd_item),
    .q_empty     (mid_empty),
    .out_wr      (res_wr),
    .out_item    (res_item),
    .out_full    (res_full)
  );

  // buffer results for the receiver
  srs_fifo #(.ITEM_T(out_t), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_item (res_item),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_item (out_item),
    .empty   (empty)
  );

  // an accepted cell keeps the front busy in the next cycle
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front took a cell but did not go busy");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible after reset");

  // no inside cell means no mass
  a_no_cells_no_mass: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.cells_inside == '0) |-> (out_item.mass_sum == '0))
    else $error("mass reported with no cells inside");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import srs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [63:0] S64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN_U = 64'h8000_0000_0000_0000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_t         in_item;
  logic        empty;
  logic        pop;
  out_t        out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [62:0] cfg_data;

  spherical_region_energy_sums_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow of the geometry and scale registers.
  logic signed [31:0] geo_off_x, geo_off_y, geo_off_z;
  logic [30:0]        geo_sp_x, geo_sp_y, geo_sp_z;
  logic [62:0]        geo_r2;
  logic [31:0]        geo_vol;

  // Shadow of the running sums.
  logic signed [63:0] mass_run, kin_run, therm_run, pot_run;
  logic [21:0]        inside_run;
  bit                 zero_dens_seen, clamp_seen;

  out_t pending_sums[$];

  int  errors;
  int  cycles;
  bit  idle_on;       // random gaps on both channels
  int  hold_request;  // receiver hold-off length, taken by the receiver
  int  hold_left;

  // Saturating add; remember any clamp.
  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, S64_MAX_U})) begin
      clamp_seen = 1'b1;
      return S64_MAX;
    end
    if (s < $signed({1'b1, S64_MIN_U})) begin
      clamp_seen = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  // Q16.16 sum times cell volume gives Q32.32, clamped to the signed range.
  function automatic logic signed [63:0] volume_scale(input logic signed [63:0] a);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [95:0] lim;
    mag  = a[63] ? -a : a;
    prod = {32'd0, mag} * {64'd0, geo_vol};
    lim  = a[63] ? {32'd0, S64_MIN_U} : {32'd0, S64_MAX_U};
    if (prod > lim) begin
      clamp_seen = 1'b1;
      return a[63] ? S64_MIN : S64_MAX;
    end
    return a[63] ? -prod[63:0] : prod[63:0];
  endfunction

  // floor(d*d/4) of one axis; overflow marks the cell as far outside.
  function automatic logic [63:0] quarter_sq(input longint d, inout bit over);
    logic [63:0] a;
    logic [63:0] e;
    a = (d < 0) ? -d : d;
    if (a >= 64'h2_0000_0000) begin
      over = 1'b1;
      return 64'd0;
    end
    e = a >> 1;
    return e * e + (a[0] ? e : 64'd0);
  endfunction

  function automatic bit cell_in_sphere(input in_t c);
    longint      dx, dy, dz;
    bit          over;
    logic [65:0] r2;
    over = 1'b0;
    dx = 2 * longint'(geo_off_x) + (2 * longint'(c.cell_x) + 1) * longint'(geo_sp_x);
    dy = 2 * longint'(geo_off_y) + (2 * longint'(c.cell_y) + 1) * longint'(geo_sp_y);
    dz = 2 * longint'(geo_off_z) + (2 * longint'(c.cell_z) + 1) * longint'(geo_sp_z);
    r2 = {2'b0, quarter_sq(dx, over)} + {2'b0, quarter_sq(dy, over)}
       + {2'b0, quarter_sq(dz, over)};
    return !over && r2[65:64] == 2'b00 && r2 <= {3'b0, geo_r2};
  endfunction

  // Fold one accepted cell into the running sums; a last cell closes the sweep.
  function automatic void accumulate_cell(input in_t c);
    logic [63:0]        dens, ax, ay, az, sq;
    longint             mx, my, mz;
    logic signed [63:0] k, t, p;
    out_t               r;
    dens = {33'd0, c.density};
    if (cell_in_sphere(c)) begin
      mass_run = clamp_add(mass_run, dens);
      if (dens == 0) begin
        zero_dens_seen = 1'b1;
      end else begin
        mx = longint'(c.momentum_x);
        my = longint'(c.momentum_y);
        mz = longint'(c.momentum_z);
        ax = (mx < 0) ? -mx : mx;
        ay = (my < 0) ? -my : my;
        az = (mz < 0) ? -mz : mz;
        sq = ax * ax + ay * ay + az * az;
        kin_run = clamp_add(kin_run, sq / (2 * dens));
      end
      therm_run = clamp_add(therm_run, ({33'd0, c.internal_energy} * dens) >> 16);
      pot_run = clamp_add(pot_run, (longint'(c.potential) * longint'(dens)) >>> 17);
      if (inside_run != COUNT_MAX) inside_run++;
    end
    if (!c.last_cell) return;
    r.mass_sum      = volume_scale(mass_run);
    k               = volume_scale(kin_run);
    t               = volume_scale(therm_run);
    p               = volume_scale(pot_run);
    r.kinetic_sum   = k;
    r.thermal_sum   = t;
    r.potential_sum = p;
    r.total_sum     = clamp_add(clamp_add(k, t), p);
    r.cells_inside  = inside_run;
    r.status        = clamp_seen ? ST_SAT : (zero_dens_seen ? ST_ZERO_DENS : ST_OK);
    pending_sums.push_back(r);
    mass_run = 0;
    kin_run = 0;
    therm_run = 0;
    pot_run = 0;
    inside_run = 0;
    zero_dens_seen = 1'b0;
    clamp_seen = 1'b0;
  endfunction

  // Present one cell, wait for it to be taken, then predict.
  task automatic send_cell(input in_t c);
    if (idle_on && $urandom_range(99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (full);
    accumulate_cell(c);
  endtask

  // Stop offering, let every expected sum arrive, then let trailing cells
  // that are still being summed finish.
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_OFFSET_X:    geo_off_x = val[31:0];
      REG_OFFSET_Y:    geo_off_y = val[31:0];
      REG_OFFSET_Z:    geo_off_z = val[31:0];
      REG_SPACING_X:   geo_sp_x  = val[30:0];
      REG_SPACING_Y:   geo_sp_y  = val[30:0];
      REG_SPACING_Z:   geo_sp_z  = val[30:0];
      REG_RADIUS_SQ:   geo_r2    = val;
      REG_CELL_VOLUME: geo_vol   = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a full geometry; all three axes share offset and spacing.
  task automatic set_geometry(input logic [31:0] off, input logic [30:0] sp,
                              input logic [62:0] r2, input logic [31:0] vol);
    write_reg(REG_OFFSET_X, {31'd0, off});
    write_reg(REG_OFFSET_Y, {31'd0, off});
    write_reg(REG_OFFSET_Z, {31'd0, off});
    write_reg(REG_SPACING_X, {32'd0, sp});
    write_reg(REG_SPACING_Y, {32'd0, sp});
    write_reg(REG_SPACING_Z, {32'd0, sp});
    write_reg(REG_RADIUS_SQ, r2);
    write_reg(REG_CELL_VOLUME, {31'd0, vol});
    cfg_we <= 1'b0;
  endtask

  function automatic in_t make_cell(input int x, input int y, input int z,
                                    input logic [31:0] m, input logic [30:0] dens,
                                    input logic [30:0] ene, input logic [31:0] pot,
                                    input bit last);
    in_t c;
    c.cell_x = 7'(x);
    c.cell_y = 7'(y);
    c.cell_z = 7'(z);
    c.momentum_x = m;
    c.momentum_y = -m;
    c.momentum_z = m;
    c.density = dens;
    c.internal_energy = ene;
    c.potential = pot;
    c.last_cell = last;
    return c;
  endfunction

  // Random cell; region > 0 mostly keeps indices near the sphere, else anywhere.
  function automatic in_t random_cell(input int region, input int last_odds);
    in_t          c;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(in_t)-1:0];
    if (region > 0 && $urandom_range(9) != 0) begin
      c.cell_x = 7'($urandom_range(region));
      c.cell_y = 7'($urandom_range(region));
      c.cell_z = 7'($urandom_range(region));
    end
    case ($urandom_range(9))
      0:       c.density = '0;
      1, 2, 3: c.density = 31'($urandom_range(32'h4_0000));
      default: ;
    endcase
    if ($urandom_range(1)) begin
      c.momentum_x = $signed($urandom_range(32'h2_0000)) - 32'sh1_0000;
      c.momentum_y = $signed($urandom_range(32'h2_0000)) - 32'sh1_0000;
    end
    if ($urandom_range(1)) c.internal_energy = 31'($urandom_range(32'h4_0000));
    c.last_cell = ($urandom_range(last_odds - 1) == 0);
    return c;
  endfunction

  // Default geometry: only the corner cell lies inside the unit sphere.
  task automatic test_directed_defaults;
    send_cell(make_cell(0, 0, 0, 32'h0002_0000, 31'h0001_0000, 31'h0000_8000,
                        32'hFFFF_0000, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b1));
    // tiny density against full momentum: kinetic clamps on the second cell
    send_cell(make_cell(0, 0, 0, 32'h8000_0000, 31'd1, 31'd0, 32'h7FFF_FFFF, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'h8000_0000, 31'd1, 31'd0, 32'h7FFF_FFFF, 1'b1));
    // clamp and zero density together report saturation
    send_cell(make_cell(0, 0, 0, 32'h8000_0000, 31'd1, 31'd0, 32'd0, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'h8000_0000, 31'd0, 31'd0, 32'd0, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'h7FFF_FFFF, 31'd1, 31'd0, 32'd0, 1'b1));
    send_cell(make_cell(0, 0, 0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h7FFF_FFFF, 1'b1));
    // outside cells: a dropped one, a zero-density one, then an outside last
    send_cell(make_cell(1, 0, 0, 32'h1234_5678, 31'h0001_0000, 31'd5, 32'd7, 1'b0));
    send_cell(make_cell(127, 127, 127, 32'h0, 31'd0, 31'd0, 32'd0, 1'b0));
    send_cell(make_cell(127, 127, 127, 32'h0, 31'd0, 31'd0, 32'd0, 1'b1));
    drain();
  endtask

  // Extreme register values: huge sphere with full scale, overflowing squares,
  // and zero spacing with zero volume.
  task automatic test_extreme_geometry;
    set_geometry(32'h8000_0000, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(make_cell(0, 0, 0, 32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0001, 1'b0));
    send_cell(make_cell(0, 0, 0, 32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0001, 1'b1));
    send_cell(make_cell(0, 1, 0, 32'h0001_0000, 31'h0001_0000, 31'd1, 32'd1, 1'b1));
    drain();
    set_geometry(32'h7FFF_FFFF, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 32'h0001_0000);
    send_cell(make_cell(0, 0, 0, 32'h0001_0000, 31'h0001_0000, 31'd1, 32'd1, 1'b0));
    send_cell(make_cell(1, 1, 1, 32'h0001_0000, 31'h0001_0000, 31'd1, 32'd1, 1'b1));
    drain();
    set_geometry(32'h0, 31'd0, 63'd0, 32'd0);
    send_cell(make_cell(0, 0, 0, 32'h0003_0000, 31'h0002_0000, 31'd9, 32'hFFFF_FFFF, 1'b0));
    send_cell(make_cell(99, 5, 64, 32'h0003_0000, 31'h0002_0000, 31'd9, 32'd3, 1'b1));
    drain();
  endtask

  // Hold the receiver off while sums pile up so the input stalls.
  task automatic test_backpressure;
    set_geometry(-32'sh0004_0000, 31'h0001_0000, 63'h9_0000_0000, 32'h0001_0000);
    hold_request = 4000;
    for (int n = 0; n < 40; n++) send_cell(random_cell(7, 1));
    drain();
  endtask

  // Several random geometries, each a sphere of a few cells near the origin.
  task automatic test_random_sweeps;
    logic [30:0] sp;
    logic [63:0] rad;
    logic [31:0] vol;
    for (int ph = 0; ph < 5; ph++) begin
      sp  = 31'($urandom_range(32'h2_0000, 32'h4000));
      rad = {33'd0, sp} * $urandom_range(4, 1);
      vol = (ph == 4) ? $urandom : $urandom_range(32'h4_0000);
      set_geometry(-(32'(sp) * 4) + $urandom_range(32'h1_0000) - 32'h8000,
                   sp, 63'(rad * rad + 64'($urandom_range(32'hFFFF))), vol);
      idle_on = (ph != 2);  // one sweep runs without gaps on either side
      for (int n = 0; n < 130; n++) send_cell(random_cell(9, 8));
      drain();
      idle_on = 1'b1;
    end
  endtask

  // Result side: random pops, optional hold-off, compare with the oldest sums.
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_sums.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          want = pending_sums.pop_front();
          check_field("mass_sum", want.mass_sum, out_item.mass_sum);
          check_field("kinetic_sum", want.kinetic_sum, out_item.kinetic_sum);
          check_field("thermal_sum", want.thermal_sum, out_item.thermal_sum);
          check_field("potential_sum", want.potential_sum, out_item.potential_sum);
          check_field("total_sum", want.total_sum, out_item.total_sum);
          check_field("cells_inside", 64'(want.cells_inside), 64'(out_item.cells_inside));
          check_field("status", 64'(want.status), 64'(out_item.status));
        end
      end
      if (hold_request != 0) begin
        hold_left <= hold_request;
        hold_request = 0;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= idle_on ? ($urandom_range(99) >= 10) : 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_request = 0;
    geo_off_x = 0;
    geo_off_y = 0;
    geo_off_z = 0;
    geo_sp_x = 31'h1_0000;
    geo_sp_y = 31'h1_0000;
    geo_sp_z = 31'h1_0000;
    geo_r2 = 63'h1_0000_0000;
    geo_vol = 32'h1_0000;
    mass_run = 0;
    kin_run = 0;
    therm_run = 0;
    pot_run = 0;
    inside_run = 0;
    zero_dens_seen = 1'b0;
    clamp_seen = 1'b0;
    rst <= 1'b1;
    push <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_extreme_geometry();
    test_backpressure();
    test_random_sweeps();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
